>>> hw/rtl/fhps_pkg.sv
// Shared types and constants for the first-hop path search block.
`timescale 1ns / 1ps
package fhps_pkg;

  localparam int MAX_LINKS   = 64;
  localparam int LINK_AW     = $clog2(MAX_LINKS);
  localparam int LINK_CW     = LINK_AW + 1;
  localparam int WORLD_W     = 8;
  localparam int WORLD_COUNT = 1 << WORLD_W;
  localparam int COORD_W     = 16;
  localparam int STACK_DEPTH = MAX_LINKS + 1;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_SAME = 2'd0,
    ST_HOP  = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    W_IDLE,
    W_CLR,
    W_INIT,
    W_PASS,
    W_LNK,
    W_VIS,
    W_BACK,
    W_POP,
    W_FOUND,
    W_RES,
    W_DONE
  } walk_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
    logic [WORLD_W-1:0]        dst;
    logic [WORLD_W-1:0]        src;
  } link_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
    logic [WORLD_W-1:0]        target;
  } query_t;

  typedef struct packed {
    status_e                   status;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } result_t;

endpackage

>>> hw/rtl/fhps_ram.sv
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module fhps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/fhps_walk.sv
// Depth-first walk sequencer with visited map and world stack.
`timescale 1ns / 1ps
module fhps_walk import fhps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  query_t             query_i,
  input  logic [WORLD_W-1:0] home_i,
  input  logic [LINK_CW-1:0] link_count_i,
  output logic [LINK_AW-1:0] link_raddr_o,
  input  link_t              link_rdata_i,
  input  logic               out_free_i,
  output logic               idle_o,
  output logic               done_o,
  output result_t            result_o
);

  walk_state_e state_q, state_d;
  logic [WORLD_W-1:0]  clr_q, clr_d;
  logic [LINK_CW-1:0]  i_q, i_d;
  logic [STACK_AW-1:0] hops_q, hops_d;
  logic [WORLD_W-1:0]  cur_q, cur_d;
  logic                moved_q, moved_d;
  logic [LINK_AW-1:0]  first_q, first_d;
  query_t              qry_q, qry_d;
  result_t             res_q, res_d;

  logic                vis_we, vis_wdata, vis_rdata;
  logic [WORLD_W-1:0]  vis_waddr;
  logic                stk_we;
  logic [STACK_AW-1:0] stk_waddr, stk_raddr;
  logic [WORLD_W-1:0]  stk_wdata, stk_rdata;
  logic                take;

  fhps_ram #(.DEPTH(WORLD_COUNT), .WIDTH(1)) u_vis (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (link_rdata_i.dst),
    .rdata_o (vis_rdata)
  );

  fhps_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORLD_W)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Move test on the link under scan
  assign take = (link_rdata_i.src == cur_q) && !vis_rdata;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      clr_q   <= '0;
      i_q     <= '0;
      hops_q  <= '0;
      cur_q   <= '0;
      moved_q <= 1'b0;
      first_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      i_q     <= i_d;
      hops_q  <= hops_d;
      cur_q   <= cur_d;
      moved_q <= moved_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q <= qry_d;
    res_q <= res_d;
  end

  // Sequence the walk
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    i_d          = i_q;
    hops_d       = hops_q;
    cur_d        = cur_q;
    moved_d      = moved_q;
    first_d      = first_q;
    qry_d        = qry_q;
    res_d        = res_q;
    vis_we       = 1'b0;
    vis_waddr    = clr_q;
    vis_wdata    = 1'b0;
    stk_we       = 1'b0;
    stk_waddr    = hops_q + STACK_AW'(1);
    stk_wdata    = link_rdata_i.dst;
    stk_raddr    = hops_q - STACK_AW'(1);
    link_raddr_o = i_q[LINK_AW-1:0];
    done_o       = 1'b0;
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          qry_d = query_i;
          if (query_i.target == home_i) begin
            res_d   = '{status: ST_SAME, y: query_i.y, x: query_i.x};
            state_d = W_DONE;
          end else begin
            clr_d   = '0;
            state_d = W_CLR;
          end
        end
      end
      W_CLR: begin
        vis_we = 1'b1;
        clr_d  = clr_q + WORLD_W'(1);
        if (&clr_q) begin
          state_d = W_INIT;
        end
      end
      W_INIT: begin
        vis_we    = 1'b1;
        vis_waddr = home_i;
        vis_wdata = 1'b1;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = home_i;
        cur_d     = home_i;
        hops_d    = '0;
        i_d       = '0;
        moved_d   = 1'b0;
        state_d   = W_PASS;
      end
      W_PASS: begin
        if (i_q == link_count_i) begin
          if (moved_q) begin
            i_d     = '0;
            moved_d = 1'b0;
          end else begin
            state_d = W_BACK;
          end
        end else begin
          state_d = W_LNK;
        end
      end
      W_LNK: begin
        state_d = W_VIS;
      end
      W_VIS: begin
        i_d     = i_q + LINK_CW'(1);
        state_d = W_PASS;
        if (take) begin
          vis_we    = 1'b1;
          vis_waddr = link_rdata_i.dst;
          vis_wdata = 1'b1;
          stk_we    = 1'b1;
          hops_d    = hops_q + STACK_AW'(1);
          cur_d     = link_rdata_i.dst;
          moved_d   = 1'b1;
          if (hops_q == '0) begin
            first_d = i_q[LINK_AW-1:0];
          end
          if (link_rdata_i.dst == qry_q.target) begin
            state_d = W_FOUND;
          end
        end
      end
      W_BACK: begin
        if (hops_q == '0) begin
          res_d   = '{status: ST_NONE, y: '0, x: '0};
          state_d = W_DONE;
        end else begin
          hops_d  = hops_q - STACK_AW'(1);
          state_d = W_POP;
        end
      end
      W_POP: begin
        cur_d   = stk_rdata;
        i_d     = '0;
        moved_d = 1'b0;
        state_d = W_PASS;
      end
      W_FOUND: begin
        link_raddr_o = first_q;
        state_d      = W_RES;
      end
      W_RES: begin
        res_d   = '{status: ST_HOP, y: link_rdata_i.y, x: link_rdata_i.x};
        state_d = W_DONE;
      end
      W_DONE: begin
        done_o = out_free_i;
        if (out_free_i) begin
          state_d = W_IDLE;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  assign idle_o   = (state_q == W_IDLE);
  assign result_o = res_q;

  // A query starts only from idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == W_IDLE)
    else $error("query started while walk busy");

  // Path never grows beyond the link table
  a_hops_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hops_q <= STACK_AW'(MAX_LINKS))
    else $error("path depth overflow");

  // A found hop always has a path behind it
  a_hop_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == W_RES) |-> hops_q != '0)
    else $error("hop reported with empty path");

  // A move lands on the scanned link's destination
  a_move_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == W_VIS && take) |=> cur_q == $past(link_rdata_i.dst))
    else $error("current world not updated on move");

endmodule

>>> hw/rtl/first_hop_path_search.sv
// Top level: link table, stream handshakes and result register.
//
// Input beats carry a kind in s_axis_tuser: load appends a link to the
// table (dropped when the table holds its limit), clear empties it, and
// query asks for the first hop from the home world toward target_world.
// Only a query gives a result beat on the master side.
// Loads and clears complete on acceptance. A query to the home world
// finishes without a walk. Any other query first sweeps the 256-entry
// visited map, then walks the link table one link at a time in passes,
// backtracking along the world stack when a pass makes no move.
// s_axis_tready is low while a query is being worked on or its result
// waits for the output register. A finished result sits there until
// taken; new beats are accepted meanwhile, but the next query's result
// waits until the register frees. Reset empties the table, sets
// home_world to 0 and drops any pending result. The user must write
// home_world through cfg_we_i only while the block is idle; the block
// does not enforce this.
`timescale 1ns / 1ps
module first_hop_path_search import fhps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // link_from[7:0], link_to[15:8], target_world[23:16],
  // coord_x[39:24], coord_y[55:40]
  input  logic [55:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_x[15:0], result_y[31:16]
  output logic [31:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  logic [WORLD_W-1:0] home_world_q;
  logic [LINK_CW-1:0] count_q, count_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;

  logic               accept, start, walk_idle, walk_done, out_free, lnk_we;
  link_t              lnk_wdata, lnk_rdata;
  logic [LINK_AW-1:0] lnk_raddr;
  query_t             qry;
  result_t            walk_res;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign lnk_wdata = '{y: s_axis_tdata[55:40], x: s_axis_tdata[39:24],
                       dst: s_axis_tdata[15:8], src: s_axis_tdata[7:0]};
  assign qry       = '{y: s_axis_tdata[55:40], x: s_axis_tdata[39:24],
                       target: s_axis_tdata[23:16]};

  // Decode the beat kind
  always_comb begin
    count_d = count_q;
    lnk_we  = 1'b0;
    start   = 1'b0;
    if (accept) begin
      unique case (s_axis_tuser)
        KIND_LOAD: begin
          if (count_q < LINK_CW'(MAX_LINKS)) begin
            lnk_we  = 1'b1;
            count_d = count_q + LINK_CW'(1);
          end
        end
        KIND_CLEAR: count_d = '0;
        KIND_QUERY: start = 1'b1;
        default: ;
      endcase
    end
  end

  // Hold config and table fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_world_q <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        home_world_q <= cfg_wdata_i;
      end
      count_q <= count_d;
    end
  end

  fhps_ram #(.DEPTH(MAX_LINKS), .WIDTH($bits(link_t))) u_links (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (count_q[LINK_AW-1:0]),
    .wdata_i (lnk_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  fhps_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .query_i      (qry),
    .home_i       (home_world_q),
    .link_count_i (count_q),
    .link_raddr_o (lnk_raddr),
    .link_rdata_i (lnk_rdata),
    .out_free_i   (out_free),
    .idle_o       (walk_idle),
    .done_o       (walk_done),
    .result_o     (walk_res)
  );

  assign s_axis_tready = walk_idle;

  // Output register: load on done, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (walk_done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_done) begin
      out_q <= walk_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.y, out_q.x};
  assign m_axis_tuser  = out_q.status;

endmodule
